// ===== hdl/per_user_request_rate_limiter_defines.svh =====
// Assertion macros shared by the rate limiter RTL
`ifndef PER_USER_REQUEST_RATE_LIMITER_DEFINES_SVH
`define PER_USER_REQUEST_RATE_LIMITER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// ante true at an edge implies cons at the same edge
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
// ante true at an edge implies cons at the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/prl_pkg.sv =====
// Shared types and constants of the per-user request rate limiter
`timescale 1ns / 1ps
package prl_pkg;

  localparam int USERS_DEF  = 64;
  localparam int WINDOW_DEF = 5;

  localparam int KEY_W  = 64;
  localparam int TIME_W = 32;
  localparam int SPAN_W = 16;

  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;

  localparam logic [SPAN_W-1:0] SPAN_RESET = 16'd10;

  // word index of the register file (paddr above the byte offset)
  localparam logic [PADDR_W-3:0] REG_SPAN = 1'b0;

  typedef enum logic [1:0] {
    T_IDLE,
    T_SEARCH,
    T_WINDOW
  } top_state_t;

  typedef enum logic {
    K_IDLE,
    K_SCAN
  } key_state_t;

  typedef enum logic [1:0] {
    W_IDLE,
    W_META,
    W_UPDATE,
    W_OLDEST
  } win_state_t;

  typedef struct packed {
    logic valid;
    logic full;
    logic is_new;
  } key_rsp_t;

  typedef struct packed {
    logic done;
    logic banned;
  } win_rsp_t;

endpackage

// ===== hdl/per_user_request_rate_limiter.sv =====
// Top level of the per-user request rate limiter: control, register port, result words
`timescale 1ns / 1ps
`include "per_user_request_rate_limiter_defines.svh"
// Sequence: the key scan reads one stored key per cycle until the key is found or all
//   stored keys are read; a new key is then allocated, or the request ends with table_full
//   if the table is full; else the ring is updated and its oldest time checked if full.
// Throughput: one request at a time; busy falls as the result word is shown, so the
//   next start is taken in the cycle done is high. The receiver cannot stall results.
// Reset: clears the stored-key count and all control; memories are not swept.
module per_user_request_rate_limiter import prl_pkg::*; #(
  parameter int USERS  = USERS_DEF,
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // request word
  input  logic                  start,
  input  logic [KEY_W-1:0]      requester_key,
  input  logic [TIME_W-1:0]     request_time,
  output logic                  busy,
  // result word
  output logic                  done,
  output logic                  banned,
  output logic                  table_full
);

  localparam int IDX_W = (USERS > 1) ? $clog2(USERS) : 1;

  top_state_t        state, state_next;
  logic [SPAN_W-1:0] span_limit;
  logic [TIME_W-1:0] time_q;
  logic              done_next;
  logic              banned_next;
  logic              table_full_next;

  logic              accept;
  logic              cfg_wr;
  logic              win_go;
  key_rsp_t          key_rsp;
  logic [IDX_W-1:0]  key_slot;
  win_rsp_t          win_rsp;

  // Register port: no wait states; only the span limit word is writable.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[PADDR_W-1:2] == REG_SPAN) ? APB_DATA_W'(span_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      span_limit <= SPAN_RESET;
    end else if (cfg_wr && paddr[PADDR_W-1:2] == REG_SPAN) begin
      span_limit <= pwdata[SPAN_W-1:0];
    end
  end

  // Request handshake: take a word whenever the control is idle.
  assign busy   = state != T_IDLE;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept) time_q <= request_time;
  end

  // Key lookup first; a full table ends the request there.
  prl_key_search #(
    .USERS (USERS)
  ) u_key_search (
    .clk  (clk),
    .rst  (rst),
    .go   (accept),
    .key  (requester_key),
    .rsp  (key_rsp),
    .slot (key_slot)
  );

  // Then the ring of the entry found or allocated is updated and checked.
  prl_window #(
    .USERS  (USERS),
    .WINDOW (WINDOW)
  ) u_window (
    .clk    (clk),
    .rst    (rst),
    .go     (win_go),
    .slot   (key_slot),
    .is_new (key_rsp.is_new),
    .now    (time_q),
    .span   (span_limit),
    .rsp    (win_rsp)
  );

  always_comb begin
    state_next = state;
    case (state)
      T_IDLE: if (accept) state_next = T_SEARCH;
      T_SEARCH: begin
        if (key_rsp.valid) state_next = key_rsp.full ? T_IDLE : T_WINDOW;
      end
      T_WINDOW: if (win_rsp.done) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_comb begin
    win_go          = 1'b0;
    done_next       = 1'b0;
    banned_next     = 1'b0;
    table_full_next = 1'b0;
    case (state)
      T_SEARCH: begin
        if (key_rsp.valid && key_rsp.full) begin
          // untracked request: flag it, never ban it
          done_next       = 1'b1;
          table_full_next = 1'b1;
        end else if (key_rsp.valid) begin
          win_go = 1'b1;
        end
      end
      T_WINDOW: begin
        if (win_rsp.done) begin
          done_next   = 1'b1;
          banned_next = win_rsp.banned;
        end
      end
      default: ;
    endcase
  end

  // Result word is registered and shown for exactly one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    banned     <= banned_next;
    table_full <= table_full_next;
  end

  `ASSERT_NEXT(a_done_one_cycle, clk, rst, done, !done)
  `ASSERT_IMPLY(a_full_not_banned, clk, rst, done && table_full, !banned)
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

endmodule

// ===== hdl/prl_key_search.sv =====
// Key table: stored keys, allocation count and a linear scan over the key memory
`timescale 1ns / 1ps
`include "per_user_request_rate_limiter_defines.svh"
module prl_key_search import prl_pkg::*; #(
  parameter int USERS = USERS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   go,
  input  logic [KEY_W-1:0]                       key,
  output key_rsp_t                               rsp,
  output logic [((USERS > 1) ? $clog2(USERS) : 1)-1:0] slot
);

  localparam int IDX_W = (USERS > 1) ? $clog2(USERS) : 1;
  localparam int CNT_W = $clog2(USERS + 1);

  key_state_t       state, state_next;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] rd_idx;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic [CNT_W-1:0] entry_count;
  logic [KEY_W-1:0] key_rdata;
  logic [KEY_W-1:0] key_mem [USERS];

  logic hit;
  logic more;
  logic rd_en;
  logic wr_en;

  assign hit  = cmp_valid && (key_rdata == key_q);
  assign more = rd_idx < entry_count;

  always_comb begin
    state_next = state;
    case (state)
      K_IDLE: if (go) state_next = K_SCAN;
      K_SCAN: if (hit || (!cmp_valid && !more)) state_next = K_IDLE;
      default: state_next = K_IDLE;
    endcase
  end

  always_comb begin
    rsp   = '0;
    slot  = cmp_idx;
    rd_en = 1'b0;
    wr_en = 1'b0;
    case (state)
      K_SCAN: begin
        if (hit) begin
          rsp.valid = 1'b1;
        end else if (!cmp_valid && !more) begin
          rsp.valid = 1'b1;
          if (entry_count == CNT_W'(USERS)) begin
            rsp.full = 1'b1;
          end else begin
            // allocate the lowest free entry: entries fill from zero upward
            rsp.is_new = 1'b1;
            slot       = entry_count[IDX_W-1:0];
            wr_en      = 1'b1;
          end
        end else if (more) begin
          rd_en = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= K_IDLE;
      entry_count <= '0;
      rd_idx      <= '0;
      cmp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == K_IDLE) begin
        rd_idx    <= '0;
        cmp_valid <= 1'b0;
      end else begin
        cmp_valid <= rd_en;
        if (rd_en) rd_idx <= rd_idx + 1'b1;
      end
      if (wr_en) entry_count <= entry_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == K_IDLE && go) key_q <= key;
    if (rd_en) cmp_idx <= rd_idx[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) key_mem[slot] <= key_q;
  end

  always_ff @(posedge clk) begin
    if (rd_en) key_rdata <= key_mem[rd_idx[IDX_W-1:0]];
  end

  `ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, entry_count <= CNT_W'(USERS))
  `ASSERT_IMPLY(a_full_at_limit, clk, rst, rsp.full, entry_count == CNT_W'(USERS))
  `ASSERT_NEXT(a_alloc_counts, clk, rst, rsp.valid && rsp.is_new, entry_count == $past(entry_count) + 1'b1)

endmodule

// ===== hdl/prl_window.sv =====
// Per-entry ring of request times: head/fill memory, time memory and span check
`timescale 1ns / 1ps
module prl_window import prl_pkg::*; #(
  parameter int USERS  = USERS_DEF,
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   go,
  input  logic [((USERS > 1) ? $clog2(USERS) : 1)-1:0] slot,
  input  logic                                   is_new,
  input  logic [TIME_W-1:0]                      now,
  input  logic [SPAN_W-1:0]                      span,
  output win_rsp_t                               rsp
);

  localparam int RING_LEN = WINDOW + 1;
  localparam int IDX_W    = (USERS > 1) ? $clog2(USERS) : 1;
  localparam int HEAD_W   = $clog2(RING_LEN);
  localparam int FILL_W   = $clog2(RING_LEN + 1);
  localparam int META_W   = HEAD_W + FILL_W;
  localparam int RA_W     = $clog2(USERS * RING_LEN);

  win_state_t        state, state_next;
  logic [IDX_W-1:0]  slot_q;
  logic [RA_W-1:0]   base_q;
  logic [TIME_W-1:0] now_q;
  logic [HEAD_W-1:0] head_q;
  logic [FILL_W-1:0] fill_q;
  logic [META_W-1:0] meta_rdata;
  logic [TIME_W-1:0] ring_rdata;
  logic [META_W-1:0] meta_mem [USERS];
  logic [TIME_W-1:0] ring_mem [USERS * RING_LEN];

  logic              ring_full;
  logic [HEAD_W-1:0] head_inc;
  logic [HEAD_W:0]   pos_sum;
  logic [HEAD_W-1:0] pos;
  logic [HEAD_W-1:0] head_new;
  logic [FILL_W-1:0] fill_new;
  logic [HEAD_W-1:0] wr_pos;
  logic              new_full;
  logic [RA_W-1:0]   ring_waddr;
  logic [RA_W-1:0]   ring_raddr;
  logic [TIME_W:0]   diff;
  logic              ban;
  logic              meta_rd_en;
  logic              meta_we;
  logic              ring_we;
  logic              ring_rd_en;

  assign ring_full = fill_q == FILL_W'(RING_LEN);
  assign head_inc  = (head_q == HEAD_W'(RING_LEN - 1)) ? '0 : head_q + 1'b1;
  assign pos_sum   = {1'b0, head_q} + (HEAD_W + 1)'(fill_q);
  assign pos       = (pos_sum >= (HEAD_W + 1)'(RING_LEN)) ?
                     HEAD_W'(pos_sum - (HEAD_W + 1)'(RING_LEN)) : HEAD_W'(pos_sum);
  // full ring: overwrite the oldest and advance the head; else append
  assign head_new   = ring_full ? head_inc : head_q;
  assign fill_new   = ring_full ? fill_q : fill_q + 1'b1;
  assign wr_pos     = ring_full ? head_q : pos;
  assign new_full   = fill_new == FILL_W'(RING_LEN);
  assign ring_waddr = base_q + RA_W'(wr_pos);
  assign ring_raddr = base_q + RA_W'(head_new);
  // time going backwards borrows and counts as a short span
  assign diff = {1'b0, now_q} - {1'b0, ring_rdata};
  assign ban  = diff[TIME_W] || (diff[TIME_W-1:0] < TIME_W'(span));

  always_comb begin
    state_next = state;
    case (state)
      W_IDLE:   if (go) state_next = is_new ? W_UPDATE : W_META;
      W_META:   state_next = W_UPDATE;
      W_UPDATE: state_next = new_full ? W_OLDEST : W_IDLE;
      W_OLDEST: state_next = W_IDLE;
      default:  state_next = W_IDLE;
    endcase
  end

  always_comb begin
    rsp        = '0;
    meta_rd_en = 1'b0;
    meta_we    = 1'b0;
    ring_we    = 1'b0;
    ring_rd_en = 1'b0;
    case (state)
      W_IDLE: meta_rd_en = go && !is_new;
      W_UPDATE: begin
        meta_we = 1'b1;
        ring_we = 1'b1;
        if (new_full) ring_rd_en = 1'b1;
        else rsp.done = 1'b1;
      end
      W_OLDEST: begin
        rsp.done   = 1'b1;
        rsp.banned = ban;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= W_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == W_IDLE && go) begin
      slot_q <= slot;
      base_q <= RA_W'(slot) * RA_W'(RING_LEN);
      now_q  <= now;
      head_q <= '0;
      fill_q <= '0;
    end else if (state == W_META) begin
      head_q <= meta_rdata[META_W-1:FILL_W];
      fill_q <= meta_rdata[FILL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[slot_q] <= {head_new, fill_new};
  end

  always_ff @(posedge clk) begin
    if (meta_rd_en) meta_rdata <= meta_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_waddr] <= now_q;
  end

  always_ff @(posedge clk) begin
    if (ring_rd_en) ring_rdata <= ring_mem[ring_raddr];
  end

endmodule
